>>> src/sprf_pkg.sv
`timescale 1ns / 1ps

package sprf_pkg;

  // reassembly buffer and fragment length word layout
  localparam int FRAG_BUF_BYTES = 32768;
  localparam int LAST_FLAG_BIT  = 14;
  localparam int TOP_FLAG_BIT   = 31;
  localparam int NEG_BIT        = 15;

  localparam int SEQ_W     = 31;
  localparam int LEN_W     = 16;
  localparam int FLEN_W    = 15;
  localparam int VERDICT_W = 3;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] REG_IS_SERVER   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_MESSAGE = 1'd1;
  localparam logic [CFG_DATA_W-1:0]  MAX_MESSAGE_RESET = 16'd32768;

  // verdict codes
  localparam logic [VERDICT_W-1:0] V_DELIVER        = 3'd0;
  localparam logic [VERDICT_W-1:0] V_OUT_OF_ORDER   = 3'd1;
  localparam logic [VERDICT_W-1:0] V_MISSED_FRAG    = 3'd2;
  localparam logic [VERDICT_W-1:0] V_ILLEGAL_LENGTH = 3'd3;
  localparam logic [VERDICT_W-1:0] V_HELD           = 3'd4;
  localparam logic [VERDICT_W-1:0] V_TOO_BIG        = 3'd5;

  typedef struct packed {
    logic [31:0] seq_word;
    logic [31:0] ack_word;
    logic [15:0] src_port;
    logic [15:0] frag_start;
    logic [15:0] frag_len_word;
    logic [15:0] payload_bytes;
  } hdr_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [SEQ_W-1:0]     skipped_count;
    logic [LEN_W-1:0]     write_offset;
    logic [LEN_W-1:0]     write_length;
    logic [LEN_W-1:0]     message_length;
    logic                 is_compressed;
    logic                 was_fragmented;
    logic [SEQ_W-1:0]     sequence_out;
    logic [SEQ_W-1:0]     ack_out;
    logic [15:0]          port_out;
  } res_t;

  typedef struct packed {
    logic [SEQ_W-1:0] incoming_seq;
    logic [SEQ_W-1:0] acked_seq;
    logic [SEQ_W-1:0] reassembly_seq;
    logic [LEN_W-1:0] reassembly_len;
  } state_t;

  typedef struct packed {
    logic            is_server;
    logic [LEN_W-1:0] max_message_bytes;
  } cfg_t;

endpackage

>>> src/sprf_hdr_if.sv
`timescale 1ns / 1ps

interface sprf_hdr_if;
  logic        valid;
  logic        ready;
  logic [31:0] seq_word;
  logic [31:0] ack_word;
  logic [15:0] src_port;
  logic [15:0] frag_start;
  logic [15:0] frag_len_word;
  logic [15:0] payload_bytes;

  modport source (
    output valid, seq_word, ack_word, src_port, frag_start, frag_len_word, payload_bytes,
    input  ready
  );

  modport sink (
    input  valid, seq_word, ack_word, src_port, frag_start, frag_len_word, payload_bytes,
    output ready
  );
endinterface

>>> src/sprf_res_if.sv
`timescale 1ns / 1ps

interface sprf_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [30:0] skipped_count;
  logic [15:0] write_offset;
  logic [15:0] write_length;
  logic [15:0] message_length;
  logic        is_compressed;
  logic        was_fragmented;
  logic [30:0] sequence_out;
  logic [30:0] ack_out;
  logic [15:0] port_out;

  modport source (
    output valid, verdict, skipped_count, write_offset, write_length, message_length,
           is_compressed, was_fragmented, sequence_out, ack_out, port_out,
    input  ready
  );

  modport sink (
    input  valid, verdict, skipped_count, write_offset, write_length, message_length,
           is_compressed, was_fragmented, sequence_out, ack_out, port_out,
    output ready
  );
endinterface

>>> src/sequenced_packet_reassembly_filter_core.sv
`timescale 1ns / 1ps

// Sequenced packet reassembly filter.
// hdr: one received packet header per transfer (valid/ready).
// res: one result per header, in order (valid/ready): verdict, skipped count,
//   buffer write offset and length of the fragment, delivered message length
//   and the flag-free sequence, ack and echoed port.
// wr_en/wr_index/wr_data: register writes, index 0 is_server, index 1
//   max_message_bytes; write only while no header is in flight.
// Path: a header taken is held in the header register; its result is then
//   loaded into the result register and shown on res, unless res is held.
// Throughput: one header per cycle while res is not held; the header register
//   feeds the decision logic and the result register directly, and the sequence
//   and reassembly state are updated in the same cycle the result is loaded.
// Stall: while res is held, the result register keeps its value and one more
//   header can wait in the header register; hdr.ready drops after that.
// Reset (rst, synchronous): both registers empty, sequence and reassembly
//   state cleared, is_server 0 and max_message_bytes 32768.
module sequenced_packet_reassembly_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  sprf_hdr_if.sink                          hdr,
  sprf_res_if.source                        res,
  input  logic                              wr_en,
  input  logic [sprf_pkg::CFG_INDEX_W-1:0]  wr_index,
  input  logic [sprf_pkg::CFG_DATA_W-1:0]   wr_data
);
  import sprf_pkg::*;

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  hdr_t   s0_item;
  logic   s0_valid;
  res_t   result;
  res_t   out_res;
  logic   out_valid;
  logic   advance;

  sprf_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  sprf_classify u_classify (
    .item    (s0_item),
    .st      (st),
    .cfg     (cfg),
    .result  (result),
    .st_next (st_next)
  );

  assign advance   = s0_valid && (!out_valid || res.ready);
  assign hdr.ready = !s0_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '0;
    end else begin
      if (hdr.ready) begin
        s0_valid <= hdr.valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.ready && hdr.valid) begin
      s0_item.seq_word      <= hdr.seq_word;
      s0_item.ack_word      <= hdr.ack_word;
      s0_item.src_port      <= hdr.src_port;
      s0_item.frag_start    <= hdr.frag_start;
      s0_item.frag_len_word <= hdr.frag_len_word;
      s0_item.payload_bytes <= hdr.payload_bytes;
    end
    if (advance) begin
      out_res <= result;
    end
  end

  assign res.valid          = out_valid;
  assign res.verdict        = out_res.verdict;
  assign res.skipped_count  = out_res.skipped_count;
  assign res.write_offset   = out_res.write_offset;
  assign res.write_length   = out_res.write_length;
  assign res.message_length = out_res.message_length;
  assign res.is_compressed  = out_res.is_compressed;
  assign res.was_fragmented = out_res.was_fragmented;
  assign res.sequence_out   = out_res.sequence_out;
  assign res.ack_out        = out_res.ack_out;
  assign res.port_out       = out_res.port_out;

  // a delivery waiting on res has already moved the incoming sequence to it
  a_deliver_seq: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.verdict == V_DELIVER) |-> (st.incoming_seq == res.sequence_out))
    else $error("incoming sequence does not match delivered packet");

  // an in-order result never leaves the incoming sequence above it
  a_order_seq: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.verdict != V_OUT_OF_ORDER) |-> (st.incoming_seq <= res.sequence_out))
    else $error("incoming sequence passed an in-order packet");

  a_buf_bound: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ({1'b0, st.reassembly_len} <= (LEN_W + 1)'(FRAG_BUF_BYTES)))
    else $error("reassembly length beyond buffer capacity");

endmodule

>>> src/sprf_cfg_regs.sv
`timescale 1ns / 1ps

module sprf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [sprf_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [sprf_pkg::CFG_DATA_W-1:0]    wr_data,
  output sprf_pkg::cfg_t                     cfg
);
  import sprf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.is_server         <= 1'b0;
      cfg.max_message_bytes <= MAX_MESSAGE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IS_SERVER:   cfg.is_server         <= wr_data[0];
        REG_MAX_MESSAGE: cfg.max_message_bytes <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/sprf_classify.sv
`timescale 1ns / 1ps

module sprf_classify (
  input  sprf_pkg::hdr_t   item,
  input  sprf_pkg::state_t st,
  input  sprf_pkg::cfg_t   cfg,
  output sprf_pkg::res_t   result,
  output sprf_pkg::state_t st_next
);
  import sprf_pkg::*;

  localparam logic [FLEN_W-1:0] LAST_MASK = FLEN_W'(1) << LAST_FLAG_BIT;
  localparam logic [LEN_W:0]    BUF_LIMIT = (LEN_W + 1)'(FRAG_BUF_BYTES);

  logic [SEQ_W-1:0]  seq;
  logic              frag;
  logic              last;
  logic              neg;
  logic [FLEN_W-1:0] flen;
  logic [LEN_W-1:0]  base_len;
  logic [LEN_W:0]    sum;
  logic              in_order;
  logic              missed;
  logic              illegal;
  logic              too_big;

  always_comb begin
    seq      = item.seq_word[SEQ_W-1:0];
    frag     = item.seq_word[TOP_FLAG_BIT];
    last     = item.frag_len_word[LAST_FLAG_BIT];
    neg      = item.frag_len_word[NEG_BIT];
    flen     = item.frag_len_word[FLEN_W-1:0] & ~LAST_MASK;
    in_order = seq > st.incoming_seq;
    // a new fragment sequence restarts the reassembly
    base_len = (seq != st.reassembly_seq) ? '0 : st.reassembly_len;
    sum      = {1'b0, base_len} + {2'b00, flen};
    missed   = item.frag_start != base_len;
    illegal  = neg || ({1'b0, flen} > item.payload_bytes) || (sum > BUF_LIMIT);
    too_big  = sum > {1'b0, cfg.max_message_bytes};

    result                = '0;
    result.is_compressed  = item.ack_word[TOP_FLAG_BIT];
    result.sequence_out   = seq;
    result.ack_out        = item.ack_word[SEQ_W-1:0];
    result.port_out       = cfg.is_server ? item.src_port : '0;
    st_next               = st;

    if (!in_order) begin
      result.verdict = V_OUT_OF_ORDER;
    end else begin
      result.skipped_count = seq - st.incoming_seq - SEQ_W'(1);
      if (frag) begin
        st_next.reassembly_seq = seq;
        st_next.reassembly_len = base_len;
        if (missed) begin
          result.verdict = V_MISSED_FRAG;
        end else if (illegal) begin
          result.verdict = V_ILLEGAL_LENGTH;
        end else begin
          result.write_offset    = base_len;
          result.write_length    = {1'b0, flen};
          st_next.reassembly_len = sum[LEN_W-1:0];
          if (!last) begin
            result.verdict = V_HELD;
          end else if (too_big) begin
            result.verdict = V_TOO_BIG;
          end else begin
            result.verdict         = V_DELIVER;
            result.message_length  = sum[LEN_W-1:0];
            result.was_fragmented  = 1'b1;
            st_next.reassembly_len = '0;
          end
        end
      end else begin
        result.verdict        = V_DELIVER;
        result.message_length = item.payload_bytes;
      end
      if (result.verdict == V_DELIVER) begin
        st_next.incoming_seq = seq;
        st_next.acked_seq    = item.ack_word[SEQ_W-1:0];
      end
    end
  end

endmodule
